// ----- rtl/drop_oldest_event_fifo_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the drop-oldest event FIFO
// Shared concurrent assertion forms, clocked on clk; DOF_ASSERT is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DROP_OLDEST_EVENT_FIFO_UNIT_DEFINES_SVH
`define DROP_OLDEST_EVENT_FIFO_UNIT_DEFINES_SVH

// Property checked at every rising edge outside reset.
`define DOF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define DOF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/dof_pkg.sv -----
// ----------------------------------------------------------------------------
// dof_pkg
// Types and codes shared by the drop-oldest event FIFO modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dof_pkg;

  localparam int EventWidth = 64;
  localparam int LostWidth  = 32;
  localparam int OccWidth   = 5;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef struct packed {
    logic                  got_item;
    logic                  is_loss_report;
    logic [LostWidth-1:0]  lost_count;
    logic [EventWidth-1:0] event_out;
    logic [OccWidth-1:0]   occupancy;
  } dof_result_t;

endpackage

`default_nettype wire

// ----- rtl/drop_oldest_event_fifo_unit.sv -----
// ----------------------------------------------------------------------------
// drop_oldest_event_fifo_unit
// Bounded event FIFO that discards its oldest entry on overflow and later
// reports the number of lost events ahead of the stored ones.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   in      | input     | in_valid / in_ready   | kind, event_word
//   out     | output    | out_valid / out_ready | got_item, is_loss_report,
//           |           |                       | lost_count, event_out,
//           |           |                       | occupancy
//
// A push, a loss report pop and an empty pop write their result to the result buffer in the cycle they are accepted.
// A pop that returns a stored event passes through ST_WAIT: the store's read port
// is registered and delivers the entry in the cycle after the address is presented.
// Reset clears the pointers, counters and loss flag; the store needs no
// clearing pass, since only written entries are ever read.
// A two-entry result buffer lets the input keep moving while the output
// stalls; the input stalls once both entries hold results.
// ----------------------------------------------------------------------------
`default_nettype none

module drop_oldest_event_fifo_unit #(
  parameter int DEPTH         = 16,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [63:0] event_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             got_item,
  output logic             is_loss_report,
  output logic [31:0]      lost_count,
  output logic [63:0]      event_out,
  output logic [4:0]       occupancy
);
  import dof_pkg::*;

  `include "drop_oldest_event_fifo_unit_defines.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [AW-1:0]  LastIdx  = AW'(DEPTH - 1);
  localparam logic [AW:0]    DepthExt = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0]  DepthCnt = CW'(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WAIT = 1'b1;

  logic                 state;
  logic [AW-1:0]        head;
  logic [CW-1:0]        count;
  logic                 loss_pending;
  logic [LostWidth-1:0] dropped_total;

  logic [AW-1:0]        head_next;
  logic [CW-1:0]        count_next;
  logic                 loss_pending_next;
  logic [LostWidth-1:0] dropped_total_next;
  logic                 state_next;

  logic                 accept;
  logic                 is_full;
  logic [AW-1:0]        head_inc;
  logic [AW:0]          tail_sum;
  logic [AW-1:0]        tail;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic                 rd_en;
  logic [PAYLOAD_WIDTH-1:0] rd_data;
  logic                 q_full;
  logic                 q_push;
  dof_result_t          q_data;
  dof_result_t          q_out;
  logic [CW:0]          occ_wide;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE) && !q_full;
  assign is_full  = (count == DepthCnt);
  assign head_inc = (head == LastIdx) ? '0 : head + AW'(1);

  // Tail slot; on a full queue the new event lands where the dropped one was.
  assign tail_sum = {1'b0, head} + (AW + 1)'(count);
  assign tail     = (tail_sum >= DepthExt) ? AW'(tail_sum - DepthExt) : AW'(tail_sum);
  assign wr_en    = accept && (kind == KIND_PUSH);
  assign wr_addr  = is_full ? head : tail;
  assign rd_en    = accept && (kind == KIND_POP) && !loss_pending && (count != '0);

  dof_ram #(
    .DEPTH (DEPTH),
    .WIDTH (PAYLOAD_WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (event_word[PAYLOAD_WIDTH-1:0]),
    .rd_en   (rd_en),
    .rd_addr (head),
    .rd_data (rd_data)
  );

  always_comb begin
    head_next          = head;
    count_next         = count;
    loss_pending_next  = loss_pending;
    dropped_total_next = dropped_total;
    state_next         = state;
    if (state == ST_WAIT) begin
      state_next = ST_IDLE;
    end else if (accept) begin
      if (kind == KIND_PUSH) begin
        if (is_full) begin
          head_next         = head_inc;
          loss_pending_next = 1'b1;
          if (dropped_total != '1) begin
            dropped_total_next = dropped_total + LostWidth'(1);
          end
        end else begin
          count_next = count + CW'(1);
        end
      end else if (loss_pending) begin
        loss_pending_next  = 1'b0;
        dropped_total_next = '0;
      end else if (count != '0) begin
        head_next  = head_inc;
        count_next = count - CW'(1);
        state_next = ST_WAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head          <= '0;
      count         <= '0;
      loss_pending  <= 1'b0;
      dropped_total <= '0;
    end else begin
      state         <= state_next;
      head          <= head_next;
      count         <= count_next;
      loss_pending  <= loss_pending_next;
      dropped_total <= dropped_total_next;
    end
  end

  // Occupancy is taken from the state as it stands after the operation.
  assign occ_wide = (CW + 1)'(count_next) + (CW + 1)'(loss_pending_next);

  always_comb begin
    q_push              = 1'b0;
    q_data.got_item       = 1'b0;
    q_data.is_loss_report = 1'b0;
    q_data.lost_count     = '0;
    q_data.event_out      = '0;
    q_data.occupancy      = OccWidth'(occ_wide);
    if (state == ST_WAIT) begin
      q_push           = 1'b1;
      q_data.got_item  = 1'b1;
      q_data.event_out = EventWidth'(rd_data);
    end else if (accept && !rd_en) begin
      q_push = 1'b1;
      if ((kind == KIND_POP) && loss_pending) begin
        q_data.got_item       = 1'b1;
        q_data.is_loss_report = 1'b1;
        q_data.lost_count     = dropped_total;
      end
    end
  end

  dof_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (q_out)
  );

  assign got_item       = q_out.got_item;
  assign is_loss_report = q_out.is_loss_report;
  assign lost_count     = q_out.lost_count;
  assign event_out      = q_out.event_out;
  assign occupancy      = q_out.occupancy;

  `DOF_ASSERT(a_read_then_wait, rd_en |=> (state == ST_WAIT), "event pop did not wait for read")
  `DOF_ASSERT(a_wait_one_cycle, (state == ST_WAIT) |=> (state == ST_IDLE), "read wait too long")
  `DOF_ASSERT(a_flag_vs_total, !loss_pending |-> (dropped_total == '0), "count without flag")
  `DOF_ASSERT(a_overflow_flags, (wr_en && is_full) |=> loss_pending, "overflow not flagged")
  `DOF_ASSERT(a_count_bound, count <= DepthCnt, "entry count above depth")

endmodule

`default_nettype wire

// ----- rtl/dof_ram.sv -----
// ----------------------------------------------------------------------------
// dof_ram
// Simple dual-port event store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dof_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dof_outq.sv -----
// ----------------------------------------------------------------------------
// dof_outq
// Two-entry result buffer that decouples the output handshake from the core.
// ----------------------------------------------------------------------------
`default_nettype none

module dof_outq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire dof_pkg::dof_result_t push_data,
  output logic                     full,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dof_pkg::dof_result_t     out_data
);
  import dof_pkg::*;

  dof_result_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = out_valid && out_ready;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire
